/* sv/bmt_pkg.sv */
// ----------------------------------------------------------------------------
// bmt_pkg
// Shared types and constants for the bounded multiset table: operation and
// status codes, field widths, and the command and status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package bmt_pkg;

  // Fixed widths of the item fields.
  localparam int FUNC_W    = 2;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int AMOUNT_W  = 7;
  localparam int ENTRIES_W = 7;

  // Operation carried by an input item.
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT     = 2'd0,
    FN_REMOVE_ONE = 2'd1,
    FN_REMOVE_ALL = 2'd2,
    FN_COUNT      = 2'd3
  } func_e_t;

  // Outcome reported with each result item.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted item, clear scan index and tally
    logic insert;    // append the value unless the store is full
    logic rd_idx;    // read the entry at the scan index
    logic advance;   // tally a match, step the index, prefetch the next entry
    logic end_scan;  // scan ran off the end: settle the status
    logic take;      // match found: shrink the store and read the last entry
    logic move;      // write the last entry into the freed slot
    logic emit;      // load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_e_t func;        // operation of the item in work
    logic    idx_lt_fill; // scan index is below the fill count
    logic    next_lt_fill;// index plus one is below the fill count
    logic    match;       // read data equals the item's value
    logic    out_free;    // result register can take a new item
  } dp_stat_t;

endpackage

/* sv/bmt_in_if.sv */
// ----------------------------------------------------------------------------
// bmt_in_if
// Input channel: valid/ready handshake carrying an operation and a value.
// ----------------------------------------------------------------------------
interface bmt_in_if;
  logic                                 valid;
  logic                                 ready;
  bmt_pkg::func_e_t                     func;
  logic signed [bmt_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

/* sv/bmt_out_if.sv */
// ----------------------------------------------------------------------------
// bmt_out_if
// Result channel: valid/ready handshake carrying status, amount and entries.
// ----------------------------------------------------------------------------
interface bmt_out_if;
  logic                               valid;
  logic                               ready;
  bmt_pkg::status_e_t                 status;
  logic [bmt_pkg::AMOUNT_W-1:0]       amount;
  logic [bmt_pkg::ENTRIES_W-1:0]      entries;

  modport source (output valid, output status, output amount, output entries, input ready);
  modport sink   (input valid, input status, input amount, input entries, output ready);
endinterface

/* sv/bmt_ram.sv */
// ----------------------------------------------------------------------------
// bmt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bmt_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/bmt_dp.sv */
// ----------------------------------------------------------------------------
// bmt_dp
// Datapath: item registers, fill count, scan index, tally, the store RAM
// and the result register.
// ----------------------------------------------------------------------------
module bmt_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bmt_pkg::ctrl_cmd_t                  cmd,
  output bmt_pkg::dp_stat_t                   stat,
  input  bmt_pkg::func_e_t                    in_func,
  input  logic signed [bmt_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bmt_pkg::status_e_t                  out_status,
  output logic [bmt_pkg::AMOUNT_W-1:0]        out_amount,
  output logic [bmt_pkg::ENTRIES_W-1:0]       out_entries
);
  import bmt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]             fill_r, fill_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic [CW-1:0]             amount_r, amount_nxt;
  func_e_t                   func_r;
  logic signed [VALUE_W-1:0] value_r;
  status_e_t                 status_r, status_nxt;
  logic                      out_valid_r;
  status_e_t                 out_status_r;
  logic [AMOUNT_W-1:0]       out_amount_r;
  logic [ENTRIES_W-1:0]      out_entries_r;

  logic [CW-1:0]      idx_inc;
  logic [CW-1:0]      fill_last;
  logic               full;
  logic               match;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_wdata, ram_rdata;

  assign idx_inc   = idx_r + 1'b1;
  assign fill_last = fill_r - 1'b1;
  assign full      = (fill_r == CW'(CAPACITY));
  assign match     = (ram_rdata == $unsigned(value_r));

  // Status towards the controller.
  always_comb begin
    stat.func         = func_r;
    stat.idx_lt_fill  = (idx_r < fill_r);
    stat.next_lt_fill = (idx_inc < fill_r);
    stat.match        = match;
    stat.out_free     = !out_valid_r || out_ready;
  end

  // Store access: appends and slot refills write, scans and the last entry read.
  assign ram_we    = (cmd.insert && !full) || cmd.move;
  assign ram_waddr = cmd.move ? idx_r[AW-1:0] : fill_r[AW-1:0];
  assign ram_wdata = cmd.move ? ram_rdata : $unsigned(value_r);
  assign ram_re    = cmd.rd_idx || cmd.take || (cmd.advance && stat.next_lt_fill);

  always_comb begin
    if (cmd.take) begin
      ram_raddr = fill_last[AW-1:0];
    end else if (cmd.advance) begin
      ram_raddr = idx_inc[AW-1:0];
    end else begin
      ram_raddr = idx_r[AW-1:0];
    end
  end

  bmt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next values of fill count, index, tally and status.
  always_comb begin
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    amount_nxt = amount_r;
    status_nxt = status_r;
    if (cmd.load) begin
      idx_nxt    = '0;
      amount_nxt = '0;
      status_nxt = ST_OK;
    end
    if (cmd.insert) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
    end
    if (cmd.advance) begin
      idx_nxt    = idx_inc;
      amount_nxt = amount_r + CW'(match);
    end
    if (cmd.take) begin
      fill_nxt   = fill_last;
      amount_nxt = amount_r + 1'b1;
    end
    if (cmd.end_scan) begin
      status_nxt = (func_r == FN_REMOVE_ONE) ? ST_NOT_FOUND : ST_OK;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and working registers.
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    amount_r <= amount_nxt;
    status_r <= status_nxt;
    if (cmd.load) begin
      func_r  <= in_func;
      value_r <= in_value;
    end
  end

  // Result register; only remove-all and count report a tally.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r  <= status_r;
      out_amount_r  <= (func_r inside {FN_REMOVE_ALL, FN_COUNT}) ?
                       AMOUNT_W'(amount_r) : '0;
      out_entries_r <= ENTRIES_W'(fill_r);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_amount  = out_amount_r;
  assign out_entries = out_entries_r;

endmodule

/* sv/bmt_ctrl.sv */
// ----------------------------------------------------------------------------
// bmt_ctrl
// Controller: sequences insert, scan, swap-remove and result hand-off.
// ----------------------------------------------------------------------------
module bmt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmt_pkg::func_e_t   in_func,
  input  bmt_pkg::dp_stat_t  stat,
  output bmt_pkg::ctrl_cmd_t cmd
);
  import bmt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INS  = 6'b000010,
    S_RD   = 6'b000100,
    S_CHK  = 6'b001000,
    S_MOVE = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   is_remove;

  assign is_remove = (stat.func == FN_REMOVE_ONE) || (stat.func == FN_REMOVE_ALL);
  assign in_ready  = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_func == FN_INSERT) ? S_INS : S_RD;
        end
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = S_DONE;
      end
      S_RD: begin
        if (stat.idx_lt_fill) begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_CHK;
        end else begin
          cmd.end_scan = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_CHK: begin
        if (stat.match && is_remove) begin
          cmd.take  = 1'b1;
          state_nxt = S_MOVE;
        end else begin
          cmd.advance = 1'b1;
          if (!stat.next_lt_fill) begin
            cmd.end_scan = 1'b1;
            state_nxt    = S_DONE;
          end
        end
      end
      S_MOVE: begin
        // The moved entry lands in the checked slot; for remove-all it is checked again.
        cmd.move  = 1'b1;
        state_nxt = (stat.func == FN_REMOVE_ONE) ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/bounded_multiset_table_top.sv */
// ----------------------------------------------------------------------------
// One item is in work at a time: a new item is accepted only after the result of
// the last one is loaded into the result register, which waits while an earlier
// result has not been taken. Reset clears the fill count and the control state;
// the store is not cleared.
// ----------------------------------------------------------------------------
// bounded_multiset_table_top
// Fixed-capacity unordered multiset of 32-bit values with insert, remove-one,
// remove-all and count operations, one result per item.
// ----------------------------------------------------------------------------
module bounded_multiset_table_top #(
  parameter int CAPACITY = 64
) (
  input logic      clk,
  input logic      rst_n,
  bmt_in_if.sink   in_ch,
  bmt_out_if.source out_ch
);
  import bmt_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  bmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_func  (in_ch.func),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_func     (in_ch.func),
    .in_value    (in_ch.value),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.status),
    .out_amount  (out_ch.amount),
    .out_entries (out_ch.entries)
  );

  // Only one item is in work: an accepted item closes the input at once.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is in work");

  // A swap-remove only follows a matching read.
  a_take_on_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> stat.match)
    else $error("swap-remove without a match");

  // A result is loaded only when the result register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result register overwritten");

  // Datapath commands other than the scan end are mutually exclusive.
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.insert, cmd.rd_idx, cmd.advance, cmd.take, cmd.move, cmd.emit}))
    else $error("conflicting datapath commands");

endmodule
